FILE: hw/rtl/cni_pkg.sv
// cni_pkg: shared types and tables for the chroma neighbor interpolation core
// used by cni_front, cni_queue, cni_back and the top level; no dependencies

package cni_pkg;

    // fixed field widths
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned CFG_W_W   = 11;
    localparam int unsigned CFG_H_W   = 13;
    localparam int unsigned MAX_ROWS  = 4096;
    localparam int unsigned SUM_W     = 11;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned RECIP_W   = 17;
    localparam int unsigned RECIP_SH  = 16;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // input op codes
    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // one column of the window as handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] above2;
        logic [SAMPLE_W-1:0] above;
        logic [SAMPLE_W-1:0] cur;
        logic                emit;
    } t_col_entry;

    // reciprocal table, ceil(2^16 / d); exact floor for sums below 2048
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/chroma_neighbor_interpolation_core.sv
// chroma_neighbor_interpolation_core: top level, config registers and clamping
// depends on cni_pkg, cni_front, cni_queue, cni_back (cni_ram below cni_front)
//
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+-------------------------------------
// s_axis   | in  | tvalid / tready         | tdata = sample, tuser = op
// m_axis   | out | tvalid / tready         | tdata = pixel_out, tlast = last_of_frame
// cfg      | in  | we (no wait)            | idx = register, data = value
//
// one request per cycle sustained while the output is not stalled; each request passes
// the line store read/write in the front, then the queue and the two registered back
// stages (neighbor sum, reciprocal multiply); result k leaves after request k+width+1
// synchronous active-low reset; line stores are never cleared, unwritten words feed
// only masked border neighbors; a stalled output fills the output register, stage a,
// the 4-entry queue and the line store stage before s_axis tready drops

module chroma_neighbor_interpolation_core
    import cni_pkg::*;
#(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // [7:0] sample
    input  logic                i_s_axis_tuser,   // [0] op
    // output stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,   // [7:0] pixel_out
    output logic                o_m_axis_tlast,
    // configuration
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [CFG_H_W-1:0]  i_cfg_data
);

    localparam int unsigned WW = $clog2(MAX_WIDTH+1);

    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [WW-1:0]      eff_w;
    logic [CFG_H_W-1:0] eff_h;
    logic               restart;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    t_col_entry         q_in;
    t_col_entry         q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 11'd640;
            r_cfg_h <= 13'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                default:          r_cfg_h <= r_cfg_h;
            endcase
        end
    end

    assign restart = i_cfg_we;

    // clamp to the supported frame size
    always_comb begin
        if (r_cfg_w < 11'd3) begin
            eff_w = WW'(3);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h < 13'd2) begin
            eff_h = 13'd2;
        end else if (r_cfg_h > 13'(MAX_ROWS)) begin
            eff_h = 13'(MAX_ROWS);
        end else begin
            eff_h = r_cfg_h;
        end
    end

    cni_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_eff_w   (eff_w),
        .i_eff_h   (eff_h),
        .i_valid   (i_s_axis_tvalid),
        .i_op      (i_s_axis_tuser),
        .i_sample  (i_s_axis_tdata),
        .o_ready   (o_s_axis_tready),
        .o_push    (q_push),
        .o_entry   (q_in),
        .i_q_full  (q_full)
    );

    cni_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    cni_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_eff_w   (eff_w),
        .i_eff_h   (eff_h),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .o_pixel   (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .i_ready   (i_m_axis_tready)
    );

endmodule

FILE: hw/rtl/cni_ram.sv
// cni_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies

module cni_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cni_front.sv
// cni_front: accepts requests, drops drains inside the frame, tracks the input
// raster position and reads/updates the two line stores; uses cni_pkg, cni_ram

module cni_front
    import cni_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   i_eff_w,
    input  logic [CFG_H_W-1:0]               i_eff_h,
    input  logic                             i_valid,
    input  logic                             i_op,
    input  logic [SAMPLE_W-1:0]              i_sample,
    output logic                             o_ready,
    output logic                             o_push,
    output t_col_entry                       o_entry,
    input  logic                             i_q_full
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH+1);

    logic [CW-1:0]       r_in_col, n_in_col;
    logic [CFG_H_W-1:0]  r_in_row, n_in_row;
    logic                r_s1_valid, n_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_x;
    logic [CW-1:0]       r_s1_col;
    logic                r_s1_emit;

    logic                accept;
    logic                in_frame;
    logic                take;
    logic                emit;
    logic                frame_end;
    logic                col_wrap;
    logic [SAMPLE_W-1:0] above;
    logic [SAMPLE_W-1:0] above2;

    // classify the request
    assign in_frame  = r_in_row < i_eff_h;
    assign o_ready   = !r_s1_valid || !i_q_full;
    assign accept    = i_valid && o_ready;
    assign take      = accept && !(in_frame && (i_op == OP_DRAIN));
    assign emit      = (r_in_row >= 13'd2) || ((r_in_row == 13'd1) && (r_in_col != '0));
    assign frame_end = (r_in_row == i_eff_h + 13'd1) && (r_in_col == '0);
    assign col_wrap  = (WW'(r_in_col) == i_eff_w - WW'(1));
    assign o_push    = r_s1_valid && !i_q_full;

    // raster position of the next taken item
    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (take) begin
            if (frame_end) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + 13'd1;
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        n_s1_valid = (r_s1_valid && !o_push) || take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_s1_valid <= 1'b0;
        end else if (i_restart) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_s1_valid <= n_s1_valid;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_s1_valid <= n_s1_valid;
        end
    end

    // payload of the line store stage
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_x    <= in_frame ? i_sample : '0;
            r_s1_col  <= r_in_col;
            r_s1_emit <= emit;
        end
    end

    // row one above, read at take and rewritten with the new sample
    cni_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .i_clk   (i_clk),
        .i_we    (o_push),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_x),
        .i_re    (take),
        .i_raddr (r_in_col),
        .o_rdata (above)
    );

    // row two above, rewritten with the row one above
    cni_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above2 (
        .i_clk   (i_clk),
        .i_we    (o_push),
        .i_waddr (r_s1_col),
        .i_wdata (above),
        .i_re    (take),
        .i_raddr (r_in_col),
        .o_rdata (above2)
    );

    // column handed to the queue
    always_comb begin
        o_entry.above2 = above2;
        o_entry.above  = above;
        o_entry.cur    = r_s1_x;
        o_entry.emit   = r_s1_emit;
    end

endmodule

FILE: hw/rtl/cni_queue.sv
// cni_queue: small flop-based fifo of window columns between front and back
// uses cni_pkg

module cni_queue
    import cni_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_col_entry i_entry,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_col_entry o_entry
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned NW = $clog2(DEPTH+1);

    t_col_entry       r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]    r_count, n_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: hw/rtl/cni_back.sv
// cni_back: 3x3 window, output raster position, neighbor mean and output register
// uses cni_pkg

module cni_back
    import cni_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_eff_w,
    input  logic [CFG_H_W-1:0]             i_eff_h,
    input  logic                           i_q_valid,
    input  t_col_entry                     i_q_entry,
    output logic                           o_pop,
    output logic                           o_valid,
    output logic [SAMPLE_W-1:0]            o_pixel,
    output logic                           o_last,
    input  logic                           i_ready
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH+1);

    logic [SAMPLE_W-1:0] r_win [9];
    logic [SAMPLE_W-1:0] n_win [9];
    logic [CW-1:0]       r_out_col;
    logic [11:0]         r_out_row;

    // stage a: neighbor sum and count
    logic                r_a_valid, n_a_valid;
    logic [SUM_W-1:0]    r_a_sum;
    logic [CNT_W-1:0]    r_a_cnt;
    logic [SAMPLE_W-1:0] r_a_center;
    logic                r_a_interp;
    logic                r_a_last;

    // output register
    logic                r_o_valid, n_o_valid;
    logic [SAMPLE_W-1:0] r_o_pixel;
    logic                r_o_last;

    logic                a_fire;
    logic                a_free;
    logic                start_a;
    logic                top_ok, bot_ok, left_ok, right_ok;
    logic                last;
    logic                interp;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    cnt;
    logic [SAMPLE_W-1:0] quot;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [7:0]          use_nb;
    logic [SAMPLE_W-1:0] nb [8];

    // handshake between stages
    assign a_fire  = r_a_valid && (!r_o_valid || i_ready);
    assign a_free  = !r_a_valid || a_fire;
    assign o_pop   = i_q_valid && a_free;
    assign start_a = o_pop && i_q_entry.emit;

    // window after shifting in the popped column
    always_comb begin
        for (int t = 0; t < 6; t++) begin
            n_win[t] = r_win[t+3];
        end
        n_win[6] = i_q_entry.above2;
        n_win[7] = i_q_entry.above;
        n_win[8] = i_q_entry.cur;
    end

    // border flags of the output position
    assign top_ok   = (r_out_row != '0);
    assign bot_ok   = ({1'b0, r_out_row} != i_eff_h - 13'd1);
    assign left_ok  = (r_out_col != '0);
    assign right_ok = (WW'(r_out_col) != i_eff_w - WW'(1));
    assign last     = !bot_ok && !right_ok;
    assign interp   = r_out_row[0] && r_out_col[0];

    // nonzero in-frame neighbors
    always_comb begin
        nb[0] = n_win[3]; use_nb[0] = top_ok;
        nb[1] = n_win[0]; use_nb[1] = top_ok && left_ok;
        nb[2] = n_win[6]; use_nb[2] = top_ok && right_ok;
        nb[3] = n_win[5]; use_nb[3] = bot_ok;
        nb[4] = n_win[2]; use_nb[4] = bot_ok && left_ok;
        nb[5] = n_win[8]; use_nb[5] = bot_ok && right_ok;
        nb[6] = n_win[1]; use_nb[6] = left_ok;
        nb[7] = n_win[7]; use_nb[7] = right_ok;
        sum = '0;
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            if (use_nb[k] && (nb[k] != '0)) begin
                sum = sum + SUM_W'(nb[k]);
                cnt = cnt + CNT_W'(1);
            end
        end
    end

    // window and output position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 9; t++) begin
                r_win[t] <= '0;
            end
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (o_pop) begin
                r_win <= n_win;
            end
            if (i_restart) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (start_a) begin
                if (last) begin
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (!right_ok) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 12'd1;
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (start_a) begin
            r_a_sum    <= sum;
            r_a_cnt    <= cnt;
            r_a_center <= n_win[4];
            r_a_interp <= interp;
            r_a_last   <= last;
        end
    end

    // division by the count through a reciprocal
    assign prod = (SUM_W+RECIP_W)'(r_a_sum) * (SUM_W+RECIP_W)'(recip(r_a_cnt));
    assign quot = prod[RECIP_SH +: SAMPLE_W];

    // valid flags
    always_comb begin
        n_a_valid = (r_a_valid && !a_fire) || start_a;
        n_o_valid = (r_o_valid && !i_ready) || a_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_o_pixel <= r_a_interp ? quot : r_a_center;
            r_o_last  <= r_a_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_o_pixel;
    assign o_last  = r_o_last;

endmodule
